@@ rtl/ctpg_pkg.sv @@
package ctpg_pkg;

    // Coordinate and phase widths
    localparam int COORD_BITS = 16;
    localparam int ANGLE_BITS = 16;

    // Configuration and gain formats
    localparam int RADIUS_W = 15;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd56;
    localparam int GAIN_W = 16;
    localparam int GAIN_BITS = 15;
    localparam logic [GAIN_W-1:0] GAIN_FULL = 16'h8000;

    // CORDIC datapath
    localparam int CORDIC_W = 64;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W = 5;
    localparam int CORDIC_SCALE = 60 - COORD_BITS;
    localparam logic [31:0] ANG_HALF = 32'h8000_0000;
    localparam logic [31:0] ANG_QUARTER = 32'h4000_0000;
    localparam logic [31:0] PHASE_ROUND =
        (ANGLE_BITS < 32) ? (32'd1 << (31 - ANGLE_BITS)) : 32'd0;

    // Magnitude: sum of squares, then root of (sum << 30)
    localparam int SQ_W = 2 * COORD_BITS;
    localparam int SQRT_STEPS = (SQ_W + 30) / 2;
    localparam int ROOT_W = SQRT_STEPS;
    localparam int REM_W = ROOT_W + 2;
    localparam int MSQ_W = 2 * RADIUS_W;
    localparam int CMP_W = (SQ_W > MSQ_W) ? SQ_W : MSQ_W;

    // Pipeline depth: front, sum, root cells, divide cells
    localparam int PIPE_DEPTH = 2 + SQRT_STEPS + GAIN_BITS;
    localparam int PHASE_DLY = PIPE_DEPTH - 1 - CORDIC_STEPS;

    typedef enum logic [1:0] {
        GS_CALC = 2'd0,
        GS_ZERO = 2'd1,
        GS_FULL = 2'd2
    } gain_sel_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] offset_x;
        logic signed [COORD_BITS-1:0] offset_y;
    } coord_item_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] phase_turns;
        logic [GAIN_W-1:0]     gain_q14;
    } result_item_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [31:0]                ang;
        logic                       zero;
    } cordic_t;

    typedef struct packed {
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        gain_sel_t         sel;
    } sqrt_t;

    typedef struct packed {
        logic [RADIUS_W-1:0]  rem;
        logic [GAIN_BITS-1:0] bits;
        logic [GAIN_BITS-1:0] quo;
        gain_sel_t            sel;
    } gdiv_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2F9;
            5'd15:   val = 32'h0000517C;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A2F;
            5'd19:   val = 32'h00000517;
            5'd20:   val = 32'h0000028B;
            5'd21:   val = 32'h00000145;
            5'd22:   val = 32'h000000A2;
            5'd23:   val = 32'h00000051;
            5'd24:   val = 32'h00000028;
            5'd25:   val = 32'h00000014;
            5'd26:   val = 32'h0000000A;
            5'd27:   val = 32'h00000005;
            5'd28:   val = 32'h00000002;
            5'd29:   val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/cartesian_to_phase_gain_top.sv @@
// Cartesian offset to phase and gain.
//
// coord channel: one request carries a signed (offset_x, offset_y) pair.
// result channel: one result per request, in order: phase_turns (atan2 plus
// a quarter turn, zero pointing up) and gain_q14 (radius over max_radius,
// clamped, doubled, 0..32768).
// cfg_we/cfg_wdata write max_radius; write it only while no request is in
// flight.
//
// Throughput: one request per cycle, sustained while the receiver does not stall.
// The pipeline depth is set by the chain of 31 square-root cells and 15
// divide cells; the 30 CORDIC cells run beside them and the phase waits in
// a short delay line.
//
// Reset clears all valid flags and loads max_radius with 56.
// When the receiver stalls, the result register holds and one more result
// drops into a skid register; coord_stall then rises and the whole chain
// freezes until the receiver takes a result.
module cartesian_to_phase_gain_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           coord_valid,
    output logic                           coord_stall,
    input  ctpg_pkg::coord_item_t          coord,
    output logic                           result_valid,
    input  logic                           result_stall,
    output ctpg_pkg::result_item_t         result,
    input  logic                           cfg_we,
    input  logic [ctpg_pkg::RADIUS_W-1:0]  cfg_wdata
);

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [ctpg_pkg::RADIUS_W-1:0] max_radius_reg;
    logic [ctpg_pkg::RADIUS_W-1:0] max_radius_next;
    logic [ctpg_pkg::MSQ_W-1:0]    m_sq_reg;
    logic [ctpg_pkg::MSQ_W-1:0]    m_sq_next;

    assign max_radius_next = cfg_we ? cfg_wdata : max_radius_reg;
    // squared radius, refreshed every cycle; settles long before it is used
    assign m_sq_next = ctpg_pkg::MSQ_W'(max_radius_reg) * ctpg_pkg::MSQ_W'(max_radius_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_radius_reg <= ctpg_pkg::RADIUS_RESET;
            m_sq_reg       <= ctpg_pkg::MSQ_W'(ctpg_pkg::RADIUS_RESET)
                              * ctpg_pkg::MSQ_W'(ctpg_pkg::RADIUS_RESET);
        end
        else
        begin
            max_radius_reg <= max_radius_next;
            m_sq_reg       <= m_sq_next;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: one enable for the whole chain, dropped only
    // while the skid register holds a result.
    // ---------------------------------------------------------------
    logic en;
    logic accept;
    logic [ctpg_pkg::PIPE_DEPTH-1:0] pipe_valid_reg;
    logic [ctpg_pkg::PIPE_DEPTH-1:0] pipe_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;

    assign en          = !skid_valid_reg;
    assign coord_stall = skid_valid_reg;
    assign accept      = coord_valid && !coord_stall;

    always_comb
    begin
        pipe_valid_next = pipe_valid_reg;
        if (en)
        begin
            pipe_valid_next = {pipe_valid_reg[ctpg_pkg::PIPE_DEPTH-2:0], accept};
        end
    end

    // ---------------------------------------------------------------
    // Front stage: sign-extend, fold the left half-plane by a half turn,
    // square the magnitudes.
    // ---------------------------------------------------------------
    logic [ctpg_pkg::COORD_BITS-1:0] dx;
    logic [ctpg_pkg::COORD_BITS-1:0] dy;
    logic [ctpg_pkg::COORD_BITS-1:0] ax;
    logic [ctpg_pkg::COORD_BITS-1:0] ay;
    logic signed [ctpg_pkg::CORDIC_W-1:0] xe;
    logic signed [ctpg_pkg::CORDIC_W-1:0] ye;
    ctpg_pkg::cordic_t front_c_reg;
    ctpg_pkg::cordic_t front_c_next;
    logic [ctpg_pkg::SQ_W-1:0] ax2_reg;
    logic [ctpg_pkg::SQ_W-1:0] ax2_next;
    logic [ctpg_pkg::SQ_W-1:0] ay2_reg;
    logic [ctpg_pkg::SQ_W-1:0] ay2_next;

    always_comb
    begin
        dx = coord.offset_x;
        dy = coord.offset_y;
        xe = {{(ctpg_pkg::CORDIC_W-ctpg_pkg::COORD_BITS){dx[ctpg_pkg::COORD_BITS-1]}}, dx}
             <<< ctpg_pkg::CORDIC_SCALE;
        ye = {{(ctpg_pkg::CORDIC_W-ctpg_pkg::COORD_BITS){dy[ctpg_pkg::COORD_BITS-1]}}, dy}
             <<< ctpg_pkg::CORDIC_SCALE;
        front_c_next.zero = (dx == '0) && (dy == '0);
        if (dx[ctpg_pkg::COORD_BITS-1])
        begin
            front_c_next.x   = -xe;
            front_c_next.y   = -ye;
            front_c_next.ang = ctpg_pkg::ANG_HALF;
        end
        else
        begin
            front_c_next.x   = xe;
            front_c_next.y   = ye;
            front_c_next.ang = '0;
        end
        // unsigned magnitude; the most negative value maps to its own bit pattern
        ax = dx[ctpg_pkg::COORD_BITS-1] ? (~dx + ctpg_pkg::COORD_BITS'(1)) : dx;
        ay = dy[ctpg_pkg::COORD_BITS-1] ? (~dy + ctpg_pkg::COORD_BITS'(1)) : dy;
        ax2_next = ctpg_pkg::SQ_W'(ax) * ctpg_pkg::SQ_W'(ax);
        ay2_next = ctpg_pkg::SQ_W'(ay) * ctpg_pkg::SQ_W'(ay);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_c_reg <= front_c_next;
            ax2_reg     <= ax2_next;
            ay2_reg     <= ay2_next;
        end
    end

    // ---------------------------------------------------------------
    // Phase: CORDIC cell row, then rounding and a delay line to line up
    // with the gain path.
    // ---------------------------------------------------------------
    ctpg_pkg::cordic_t c_bus [0:ctpg_pkg::CORDIC_STEPS];

    assign c_bus[0] = front_c_reg;

    for (genvar i = 0; i < ctpg_pkg::CORDIC_STEPS; i++)
    begin : g_cordic
        ctpg_cordic_cell u_cell (
            .clk  (clk),
            .en   (en),
            .step (ctpg_pkg::STEP_W'(i)),
            .din  (c_bus[i]),
            .dout (c_bus[i+1])
        );
    end

    logic [31:0] ang_fin;
    logic [31:0] ang_sum;
    logic [ctpg_pkg::ANGLE_BITS-1:0] phase_dly_reg [0:ctpg_pkg::PHASE_DLY-1];
    logic [ctpg_pkg::ANGLE_BITS-1:0] phase_dly_next;

    always_comb
    begin
        // zero offset: the rotation result is meaningless, report a quarter turn
        ang_fin = c_bus[ctpg_pkg::CORDIC_STEPS].zero ? '0 : c_bus[ctpg_pkg::CORDIC_STEPS].ang;
        ang_sum = ang_fin + ctpg_pkg::ANG_QUARTER + ctpg_pkg::PHASE_ROUND;
        phase_dly_next = ang_sum[31 -: ctpg_pkg::ANGLE_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phase_dly_reg[0] <= phase_dly_next;
            for (int k = 1; k < ctpg_pkg::PHASE_DLY; k++)
            begin
                phase_dly_reg[k] <= phase_dly_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Gain: sum of squares and clamp decision, square-root row,
    // divide row.
    // ---------------------------------------------------------------
    logic [ctpg_pkg::SQ_W-1:0] s_sum;
    ctpg_pkg::sqrt_t sq_init_reg;
    ctpg_pkg::sqrt_t sq_init_next;

    always_comb
    begin
        s_sum = ax2_reg + ay2_reg;
        sq_init_next.rad  = s_sum;
        sq_init_next.rem  = '0;
        sq_init_next.root = '0;
        if (max_radius_reg == '0)
        begin
            sq_init_next.sel = ctpg_pkg::GS_ZERO;
        end
        else if (ctpg_pkg::CMP_W'(s_sum) >= ctpg_pkg::CMP_W'(m_sq_reg))
        begin
            sq_init_next.sel = ctpg_pkg::GS_FULL;
        end
        else
        begin
            sq_init_next.sel = ctpg_pkg::GS_CALC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_init_reg <= sq_init_next;
        end
    end

    ctpg_pkg::sqrt_t sq_bus [0:ctpg_pkg::SQRT_STEPS];

    assign sq_bus[0] = sq_init_reg;

    for (genvar i = 0; i < ctpg_pkg::SQRT_STEPS; i++)
    begin : g_sqrt
        ctpg_sqrt_cell u_cell (
            .clk  (clk),
            .en   (en),
            .din  (sq_bus[i]),
            .dout (sq_bus[i+1])
        );
    end

    // root = floor(2^15 * sqrt(s)); gain = floor(root / max_radius)
    logic [ctpg_pkg::ROOT_W-1:0] root_hi;
    ctpg_pkg::gdiv_t d_init;
    ctpg_pkg::gdiv_t d_bus [0:ctpg_pkg::GAIN_BITS];

    assign root_hi = sq_bus[ctpg_pkg::SQRT_STEPS].root >> ctpg_pkg::GAIN_BITS;

    always_comb
    begin
        d_init.rem  = root_hi[ctpg_pkg::RADIUS_W-1:0];
        d_init.bits = sq_bus[ctpg_pkg::SQRT_STEPS].root[ctpg_pkg::GAIN_BITS-1:0];
        d_init.quo  = '0;
        d_init.sel  = sq_bus[ctpg_pkg::SQRT_STEPS].sel;
    end

    assign d_bus[0] = d_init;

    for (genvar i = 0; i < ctpg_pkg::GAIN_BITS; i++)
    begin : g_div
        ctpg_div_cell u_cell (
            .clk    (clk),
            .en     (en),
            .radius (max_radius_reg),
            .din    (d_bus[i]),
            .dout   (d_bus[i+1])
        );
    end

    // ---------------------------------------------------------------
    // Result assembly, output register and skid register
    // ---------------------------------------------------------------
    ctpg_pkg::result_item_t p_item;
    logic p_valid;

    always_comb
    begin
        p_item.phase_turns = phase_dly_reg[ctpg_pkg::PHASE_DLY-1];
        case (d_bus[ctpg_pkg::GAIN_BITS].sel)
            ctpg_pkg::GS_FULL: p_item.gain_q14 = ctpg_pkg::GAIN_FULL;
            ctpg_pkg::GS_ZERO: p_item.gain_q14 = '0;
            default:           p_item.gain_q14 = ctpg_pkg::GAIN_W'(d_bus[ctpg_pkg::GAIN_BITS].quo);
        endcase
    end

    assign p_valid = pipe_valid_reg[ctpg_pkg::PIPE_DEPTH-1];

    logic result_valid_reg;
    logic result_valid_next;
    ctpg_pkg::result_item_t result_reg;
    ctpg_pkg::result_item_t result_next;
    ctpg_pkg::result_item_t skid_reg;
    ctpg_pkg::result_item_t skid_next;
    logic take;

    assign take = result_valid_reg && !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg && !take;
        result_next       = result_reg;
        skid_valid_next   = skid_valid_reg;
        skid_next         = skid_reg;
        if (skid_valid_reg)
        begin
            // chain is frozen; drain the skid first
            if (!result_valid_reg || take)
            begin
                result_next       = skid_reg;
                result_valid_next = 1'b1;
                skid_valid_next   = 1'b0;
            end
        end
        else if (p_valid)
        begin
            if (!result_valid_reg || take)
            begin
                result_next       = p_item;
                result_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = p_item;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg   <= '0;
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            pipe_valid_reg   <= pipe_valid_next;
            result_valid_reg <= result_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        skid_reg   <= skid_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pipe_valid_reg[0])
        else $error("accepted request did not enter the front stage");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(result_valid_reg && result_stall && p_valid))
        else $error("skid filled without a stalled output and a finished request");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && take) |=> !skid_valid_reg)
        else $error("skid did not drain after the output was taken");

endmodule

@@ rtl/ctpg_cordic_cell.sv @@
// One vectoring micro-rotation, registered.
module ctpg_cordic_cell (
    input  logic                        clk,
    input  logic                        en,
    input  logic [ctpg_pkg::STEP_W-1:0] step,
    input  ctpg_pkg::cordic_t           din,
    output ctpg_pkg::cordic_t           dout
);

    ctpg_pkg::cordic_t data_reg;
    ctpg_pkg::cordic_t data_next;
    logic signed [ctpg_pkg::CORDIC_W-1:0] xs;
    logic signed [ctpg_pkg::CORDIC_W-1:0] ys;
    logic [31:0] rot;

    always_comb
    begin
        xs = $signed(din.x) >>> step;
        ys = $signed(din.y) >>> step;
        rot = ctpg_pkg::atan_entry(step);
        data_next = din;
        // rotate toward the x axis, steering on the sign of y
        if (!din.y[ctpg_pkg::CORDIC_W-1])
        begin
            data_next.x   = din.x + ys;
            data_next.y   = din.y - xs;
            data_next.ang = din.ang + rot;
        end
        else
        begin
            data_next.x   = din.x - ys;
            data_next.y   = din.y + xs;
            data_next.ang = din.ang - rot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

@@ rtl/ctpg_sqrt_cell.sv @@
// One digit of a restoring square root: two radicand bits in, one root bit out.
module ctpg_sqrt_cell (
    input  logic            clk,
    input  logic            en,
    input  ctpg_pkg::sqrt_t din,
    output ctpg_pkg::sqrt_t dout
);

    ctpg_pkg::sqrt_t data_reg;
    ctpg_pkg::sqrt_t data_next;
    logic [ctpg_pkg::REM_W+1:0]  rem_t;
    logic [ctpg_pkg::ROOT_W+1:0] trial;
    logic ge;

    always_comb
    begin
        rem_t = {din.rem, din.rad[ctpg_pkg::SQ_W-1 -: 2]};
        trial = {din.root, 2'b01};
        ge = rem_t >= (ctpg_pkg::REM_W+2)'(trial);
        data_next = din;
        data_next.rad = {din.rad[ctpg_pkg::SQ_W-3:0], 2'b00};
        if (ge)
        begin
            data_next.rem  = ctpg_pkg::REM_W'(rem_t - (ctpg_pkg::REM_W+2)'(trial));
            data_next.root = {din.root[ctpg_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = ctpg_pkg::REM_W'(rem_t);
            data_next.root = {din.root[ctpg_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

@@ rtl/ctpg_div_cell.sv @@
// One quotient bit of a restoring divide by the configured radius.
module ctpg_div_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ctpg_pkg::RADIUS_W-1:0] radius,
    input  ctpg_pkg::gdiv_t               din,
    output ctpg_pkg::gdiv_t               dout
);

    ctpg_pkg::gdiv_t data_reg;
    ctpg_pkg::gdiv_t data_next;
    logic [ctpg_pkg::RADIUS_W:0] rem_t;
    logic ge;

    always_comb
    begin
        rem_t = {din.rem, din.bits[ctpg_pkg::GAIN_BITS-1]};
        ge = rem_t >= {1'b0, radius};
        data_next = din;
        data_next.bits = {din.bits[ctpg_pkg::GAIN_BITS-2:0], 1'b0};
        data_next.quo  = {din.quo[ctpg_pkg::GAIN_BITS-2:0], ge};
        if (ge)
        begin
            data_next.rem = ctpg_pkg::RADIUS_W'(rem_t - {1'b0, radius});
        end
        else
        begin
            data_next.rem = ctpg_pkg::RADIUS_W'(rem_t);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule
